FILE: src/bgi_pkg.sv
package bgi_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int BANKS = 16;
    localparam int BOX_W = 12;
    localparam int HP_STAGES = 12;

    typedef enum logic [2:0] {
        REG_X_ORIGIN = 3'd0,
        REG_Y_ORIGIN = 3'd1,
        REG_X_INV    = 3'd2,
        REG_Y_INV    = 3'd3,
        REG_X_POINTS = 3'd4,
        REG_Y_POINTS = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic               op;
        logic [15:0]        coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               outside_grid;
        logic               is_eval;
    } rsp_t;

    typedef struct packed {
        logic                       is_eval;
        logic                       outside;
        logic [31:0]                t;
        logic [31:0]                u;
        logic [BANKS-1:0][31:0]     c;
        logic [3:0][31:0]           g;
        logic [3:0][63:0]           prod;
    } hp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // odd stage: multiply; even stage: scale, saturate, add
    function automatic hp_t hp_step(input logic [3:0] k, input hp_t x);
        hp_t                y;
        int                 ii;
        logic signed [31:0] q;
        logic signed [63:0] p;
        y  = x;
        ii = int'((k - 4'd1) >> 1);
        if (ii < 3)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (k[0])
                begin
                    p = 64'($signed(x.g[r])) * 64'($signed(x.u));
                    y.prod[r] = p;
                end
                else
                begin
                    q = sat32(64'($signed(x.prod[r]) >>> 16));
                    y.g[r] = sat32(64'(q) + 64'($signed(x.c[r*4 + 2 - ii])));
                end
            end
        end
        else
        begin
            if (k[0])
            begin
                p = 64'($signed(x.g[3])) * 64'($signed(x.t));
                y.prod[0] = p;
            end
            else
            begin
                q = sat32(64'($signed(x.prod[0]) >>> 16));
                y.g[3] = sat32(64'(q) + 64'($signed(x.g[2 - (ii - 3)])));
            end
        end
        return y;
    endfunction

endpackage

FILE: src/bgi_axis.sv
module bgi_axis
    import bgi_pkg::*;
#(
    parameter int NW = 7,
    parameter int KW = 6
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] p,
    input  logic signed [31:0] org,
    input  logic [30:0]        inv,
    input  logic [NW-1:0]      n,
    output logic [KW-1:0]      k,
    output logic [31:0]        off,
    output logic               outside
);

    logic signed [32:0] d_reg;
    logic signed [32:0] d_next;
    logic signed [47:0] s_reg;
    logic signed [63:0] prod;
    logic signed [47:0] s_next;
    logic [KW-1:0]      k_reg;
    logic [KW-1:0]      k_next;
    logic [31:0]        off_reg;
    logic [31:0]        off_next;
    logic               out_reg;
    logic               out_next;
    logic signed [31:0] k32;
    logic signed [31:0] last;
    logic signed [31:0] kc;
    logic signed [47:0] lim;

    always_comb
    begin
        d_next   = 33'(p) - 33'(org);
        prod     = 64'(d_reg) * $signed({33'b0, inv});
        s_next   = prod[63:16];
        k32      = s_reg[47:16];
        last     = $signed(32'(n)) - 32'sd2;
        if (k32 < 0)
            kc = '0;
        else if (k32 > last)
            kc = last;
        else
            kc = k32;
        lim      = $signed((48'(n) - 48'd1) << 16);
        out_next = (s_reg < 0) || (s_reg > lim);
        off_next = sat32(64'(s_reg) - (64'(kc) <<< 16));
        k_next   = kc[KW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            s_reg   <= s_next;
            k_reg   <= k_next;
            off_reg <= off_next;
            out_reg <= out_next;
        end
    end

    assign k       = k_reg;
    assign off     = off_reg;
    assign outside = out_reg;

endmodule

FILE: src/bicubic_grid_interpolator.sv
// Bicubic grid interpolator.
// Request channel (req_valid, req_stall, req): a write transfer stores one
// coefficient at coef_index; an evaluate transfer interpolates at pos_x, pos_y.
// Response channel (rsp_valid, rsp_stall, rsp): one transfer per request, in
// order; writes answer with value 0 and is_eval 0.
// Grid geometry is set through the APB port and must only change while idle.
// From request to response the pipeline has three locate stages, one box
// address stage, one coefficient read from sixteen banked memories, and twelve
// Horner stages (a multiply stage and a saturating add stage per step).
// Throughput is one transfer per cycle while no response stalls (single shared pipeline).
// Reset clears all valid bits and loads the geometry defaults; the coefficient
// store holds nothing defined until written, and needs no clearing pass.
// When a valid response stalls, the whole pipeline holds and req_stall rises in the
// same cycle; nothing is lost or repeated.
module bicubic_grid_interpolator
    import bgi_pkg::*;
#(
    parameter int GRID_POINTS_MAX = 64,
    parameter int COEF_BITS       = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int KW = (GRID_POINTS_MAX > 2) ? $clog2(GRID_POINTS_MAX) : 1;
    localparam int NW = $clog2(GRID_POINTS_MAX + 1);
    localparam int CW = (COEF_BITS < 32) ? COEF_BITS : 32;
    localparam int ROWS = 1 << BOX_W;

    logic signed [31:0] x_origin_reg;
    logic signed [31:0] y_origin_reg;
    logic [30:0]        x_inv_reg;
    logic [30:0]        y_inv_reg;
    logic [6:0]         x_points_reg;
    logic [6:0]         y_points_reg;
    reg_idx_t           widx;
    logic               en;

    logic [NW-1:0]      nx;
    logic [NW-1:0]      ny;
    logic [KW-1:0]      kx;
    logic [KW-1:0]      ky;
    logic [31:0]        tx;
    logic [31:0]        uy;
    logic               ox;
    logic               oy;

    logic               fr_vld_reg [1:3];
    req_t               fr_reg     [1:3];

    logic               b_vld_reg;
    logic               b_op_reg;
    logic [15:0]        b_idx_reg;
    logic [31:0]        b_val_reg;
    logic [BOX_W-1:0]   b_box_reg;
    logic [31:0]        b_t_reg;
    logic [31:0]        b_u_reg;
    logic               b_out_reg;
    logic [31:0]        box_w;
    logic [BOX_W-1:0]   box_next;

    logic               m_vld_reg;
    logic               m_eval_reg;
    logic [31:0]        m_t_reg;
    logic [31:0]        m_u_reg;
    logic               m_out_reg;
    logic signed [CW-1:0] rd_reg [BANKS];

    hp_t                x0;
    hp_t                hp_reg  [1:HP_STAGES];
    logic               vld_reg [1:HP_STAGES];

    assign en        = !(vld_reg[HP_STAGES] && rsp_stall);
    assign req_stall = !en;
    assign pready    = 1'b1;
    assign widx      = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            x_inv_reg    <= 31'd65536;
            y_inv_reg    <= 31'd65536;
            x_points_reg <= 7'd64;
            y_points_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_X_ORIGIN: x_origin_reg <= pwdata;
                REG_Y_ORIGIN: y_origin_reg <= pwdata;
                REG_X_INV:    x_inv_reg    <= pwdata[30:0];
                REG_Y_INV:    y_inv_reg    <= pwdata[30:0];
                REG_X_POINTS: x_points_reg <= pwdata[6:0];
                REG_Y_POINTS: y_points_reg <= pwdata[6:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_X_ORIGIN: prdata = x_origin_reg;
            REG_Y_ORIGIN: prdata = y_origin_reg;
            REG_X_INV:    prdata = {1'b0, x_inv_reg};
            REG_Y_INV:    prdata = {1'b0, y_inv_reg};
            REG_X_POINTS: prdata = {25'b0, x_points_reg};
            REG_Y_POINTS: prdata = {25'b0, y_points_reg};
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        if (x_points_reg < 7'd2)
            nx = NW'(2);
        else if (32'(x_points_reg) > 32'(GRID_POINTS_MAX))
            nx = NW'(GRID_POINTS_MAX);
        else
            nx = NW'(x_points_reg);
        if (y_points_reg < 7'd2)
            ny = NW'(2);
        else if (32'(y_points_reg) > 32'(GRID_POINTS_MAX))
            ny = NW'(GRID_POINTS_MAX);
        else
            ny = NW'(y_points_reg);
    end

    bgi_axis #(.NW(NW), .KW(KW)) u_axis_x
    (
        .clk     (clk),
        .en      (en),
        .p       (req.pos_x),
        .org     (x_origin_reg),
        .inv     (x_inv_reg),
        .n       (nx),
        .k       (kx),
        .off     (tx),
        .outside (ox)
    );

    bgi_axis #(.NW(NW), .KW(KW)) u_axis_y
    (
        .clk     (clk),
        .en      (en),
        .p       (req.pos_y),
        .org     (y_origin_reg),
        .inv     (y_inv_reg),
        .n       (ny),
        .k       (ky),
        .off     (uy),
        .outside (oy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 3; i++)
                fr_vld_reg[i] <= 1'b0;
            b_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            for (int i = 1; i <= HP_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            fr_vld_reg[1] <= req_valid;
            fr_vld_reg[2] <= fr_vld_reg[1];
            fr_vld_reg[3] <= fr_vld_reg[2];
            b_vld_reg     <= fr_vld_reg[3];
            m_vld_reg     <= b_vld_reg;
            vld_reg[1]    <= m_vld_reg;
            for (int i = 2; i <= HP_STAGES; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign box_w    = 32'(kx) * 32'(ny) + 32'(ky);
    assign box_next = box_w[BOX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg[1]  <= req;
            fr_reg[2]  <= fr_reg[1];
            fr_reg[3]  <= fr_reg[2];
            b_op_reg   <= fr_reg[3].op;
            b_idx_reg  <= fr_reg[3].coef_index;
            b_val_reg  <= fr_reg[3].coef_value;
            b_box_reg  <= box_next;
            b_t_reg    <= tx;
            b_u_reg    <= uy;
            b_out_reg  <= ox || oy;
            m_eval_reg <= (b_op_reg == OP_EVAL);
            m_t_reg    <= b_t_reg;
            m_u_reg    <= b_u_reg;
            m_out_reg  <= b_out_reg;
        end
    end

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [CW-1:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (b_vld_reg && (b_op_reg == OP_WRITE) && (b_idx_reg[3:0] == 4'(b)))
                    mem[b_idx_reg[15:4]] <= b_val_reg[CW-1:0];
                rd_reg[b] <= mem[b_box_reg];
            end
        end
    end

    always_comb
    begin
        x0         = '0;
        x0.is_eval = m_eval_reg;
        x0.outside = m_out_reg;
        x0.t       = m_t_reg;
        x0.u       = m_u_reg;
        for (int b = 0; b < BANKS; b++)
            x0.c[b] = 32'(rd_reg[b]);
        for (int r = 0; r < 4; r++)
            x0.g[r] = 32'(rd_reg[r*4 + 3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg[1] <= hp_step(4'd1, x0);
            for (int k = 2; k <= HP_STAGES; k++)
                hp_reg[k] <= hp_step(4'(k), hp_reg[k-1]);
        end
    end

    assign rsp_valid        = vld_reg[HP_STAGES];
    assign rsp.is_eval      = hp_reg[HP_STAGES].is_eval;
    assign rsp.outside_grid = hp_reg[HP_STAGES].is_eval && hp_reg[HP_STAGES].outside;
    assign rsp.value        = hp_reg[HP_STAGES].is_eval ? hp_reg[HP_STAGES].g[3] : '0;

endmodule

FILE: src/bgi_checker.sv
module bgi_checker
    import bgi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input req_t        req,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input rsp_t        rsp,
    input logic        pready
);

    // hold a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_eval |-> rsp.value == 32'd0 && !rsp.outside_grid)
        else $error("write acknowledge carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow response stall");

    // hold a stalled request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed");

    assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind bicubic_grid_interpolator bgi_checker u_bgi_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pready    (pready)
);
